// ===== rtl/core/sdf_pkg.sv =====
// ----------------------------------------------------------------------------
// sdf_pkg
// Shared constants and types of the smoothstep distance falloff unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sdf_pkg;

    localparam int DIST_FRAC_BITS_DEF = 8;
    localparam int Q_FRAC_BITS_DEF    = 16;

    // guard bits kept on the start distance before squaring
    localparam int GUARD_BITS    = 8;
    // cycles after reset or a register write until derived settings are valid
    localparam int SETTLE_CYCLES = 4;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_DIST   = 2'd0,
        CFG_START_FRAC = 2'd1,
        CFG_MIN_Q      = 2'd2
    } t_cfg_idx;

    // per-request control that travels beside the data
    typedef struct packed {
        logic valid;
        logic last;
        logic byp;      // result decided at the input stage
        logic byp_one;  // bypass value: one, else the floor quality
    } t_ctrl;

endpackage

`default_nettype wire

// ===== rtl/core/sdf_div_cell.sv =====
// ----------------------------------------------------------------------------
// sdf_div_cell
// One restoring division cell: produces one quotient bit per request.
// ----------------------------------------------------------------------------
`default_nettype none

module sdf_div_cell #(
    parameter int DW = 32,
    parameter int QW = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire sdf_pkg::t_ctrl   i_ctrl,
    input  wire logic [DW-1:0]    i_rem,
    input  wire logic [QW-1:0]    i_quot,
    input  wire logic [DW-1:0]    i_span,
    output sdf_pkg::t_ctrl        o_ctrl,
    output logic      [DW-1:0]    o_rem,
    output logic      [QW-1:0]    o_quot
);
    import sdf_pkg::*;

    t_ctrl       r_ctrl;
    logic [DW-1:0] r_rem;
    logic [QW-1:0] r_quot;

    logic [DW:0]   trial;
    logic          ge;
    logic [DW:0]   diff;
    logic [DW-1:0] n_rem;
    logic [QW-1:0] n_quot;

    always_comb begin
        trial  = {i_rem, 1'b0};
        ge     = (trial >= {1'b0, i_span});
        diff   = trial - {1'b0, i_span};
        n_rem  = ge ? diff[DW-1:0] : trial[DW-1:0];
        n_quot = {i_quot[QW-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else begin
            r_ctrl <= i_ctrl;
        end
        r_rem  <= n_rem;
        r_quot <= n_quot;
    end

    assign o_ctrl = r_ctrl;
    assign o_rem  = r_rem;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

// ===== rtl/core/sdf_curve.sv =====
// ----------------------------------------------------------------------------
// sdf_curve
// Smoothstep shaping of the ratio and mapping into the quality range.
// ----------------------------------------------------------------------------
`default_nettype none

module sdf_curve #(
    parameter int QF = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire sdf_pkg::t_ctrl   i_ctrl,
    input  wire logic [QF-1:0]    i_t,
    input  wire logic [QF:0]      i_mq,
    output logic                  o_valid,
    output logic                  o_last,
    output logic      [QF:0]      o_q
);
    import sdf_pkg::*;

    localparam logic [QF+1:0] ONE_W   = (QF+2)'(1) << QF;
    localparam logic [QF+1:0] THREE_W = (QF+2)'(3) << QF;
    localparam logic [QF:0]   ONE     = (QF+1)'(1) << QF;

    t_ctrl         r_c1, r_c2, r_c3;
    logic [QF-1:0] r_t2;
    logic [QF+1:0] r_k;
    logic [QF:0]   r_s;
    logic [QF:0]   r_q;

    logic [2*QF-1:0]   sq;
    logic [2*QF+1:0]   sk;
    logic [QF+1:0]     s_full;
    logic [QF:0]       n_s;
    logic [2*QF+1:0]   fall;
    logic [QF+1:0]     q_full;
    logic [QF:0]       n_q;

    always_comb begin
        sq     = i_t * i_t;
        sk     = r_t2 * r_k;
        s_full = sk[2*QF+1:QF];
        n_s    = (s_full > ONE_W) ? ONE : s_full[QF:0];
        fall   = r_s * (ONE - i_mq);
        q_full = ONE_W - fall[2*QF+1:QF];
        if (q_full > ONE_W) begin
            n_q = ONE;
        end else if (q_full < {1'b0, i_mq}) begin
            n_q = i_mq;
        end else begin
            n_q = q_full[QF:0];
        end
        if (r_c2.byp) begin
            n_q = r_c2.byp_one ? ONE : i_mq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1 <= '0;
            r_c2 <= '0;
            r_c3 <= '0;
        end else begin
            r_c1 <= i_ctrl;
            r_c2 <= r_c1;
            r_c3 <= r_c2;
        end
        r_t2 <= sq[2*QF-1:QF];
        r_k  <= THREE_W - {1'b0, i_t, 1'b0};
        r_s  <= n_s;
        r_q  <= n_q;
    end

    assign o_valid = r_c3.valid;
    assign o_last  = r_c3.last;
    assign o_q     = r_q;

endmodule

`default_nettype wire

// ===== rtl/core/smoothstep_distance_falloff_unit.sv =====
// ----------------------------------------------------------------------------
// smoothstep_distance_falloff_unit
// Maps a squared distance to a quality factor along a smoothstep falloff.
// a request passes the input stage, the chain of division cells and the curve registers to the o_valid strobe
// throughput: one request per cycle while busy is low; the chain of division cells sets the latency
// busy is high after reset and after each register write while
// the derived thresholds settle; the receiver cannot stall the result strobe
// ----------------------------------------------------------------------------
`default_nettype none

module smoothstep_distance_falloff_unit #(
    parameter int DIST_FRAC_BITS = sdf_pkg::DIST_FRAC_BITS_DEF,
    parameter int Q_FRAC_BITS    = sdf_pkg::Q_FRAC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [sdf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [sdf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [31:0]                   i_dist_sq,
    input  wire logic                          i_last,
    output logic                               o_valid,
    output logic      [16:0]                   o_quality,
    output logic                               o_last_res
);
    import sdf_pkg::*;

    localparam int QF  = Q_FRAC_BITS;
    localparam int DW  = 32;
    localparam int SDW = 16 + QF - (QF - GUARD_BITS);
    localparam logic [31:0] FRAC_LO  = 32'((64'd15 << QF) / 100);
    localparam logic [31:0] FRAC_HI  = 32'((64'd95 << QF) / 100);
    localparam logic [31:0] MINQ_LO  = 32'((64'd5 << QF) / 100);
    localparam logic [31:0] ONE_32   = 32'(64'd1 << QF);
    localparam logic [31:0] SPAN_MIN = 32'((64'd1 << (2 * DIST_FRAC_BITS)) / 10000);
    localparam logic [2:0]  SETTLE   = 3'(SETTLE_CYCLES);

    // register file
    logic [15:0] r_md, r_sf;
    logic [16:0] r_mq;
    logic [2:0]  r_settle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_md     <= '0;
            r_sf     <= 16'd32768;
            r_mq     <= 17'd32768;
            r_settle <= SETTLE;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MAX_DIST:   r_md <= i_cfg_data[15:0];
                CFG_START_FRAC: r_sf <= i_cfg_data[15:0];
                CFG_MIN_Q:      r_mq <= i_cfg_data[16:0];
                default:        ;
            endcase
            r_settle <= SETTLE;
        end else if (r_settle != '0) begin
            r_settle <= r_settle - 3'd1;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign busy        = (r_settle != '0);

    // derived thresholds, settled through registers while busy is high
    logic [31:0]       sf_w, mq_w, fc_w, mqc_w;
    logic [QF-1:0]     r_fc;
    logic [QF:0]       r_mqc;
    logic [15+QF:0]    prod;
    logic [SDW-1:0]    r_sd;
    logic [31:0]       r_maxsq, r_start, r_span;
    logic [2*SDW-1:0]  sd_sq;
    logic              r_narrow, r_md_zero;

    always_comb begin
        sf_w  = 32'(r_sf);
        mq_w  = 32'(r_mq);
        fc_w  = (sf_w < FRAC_LO) ? FRAC_LO : ((sf_w > FRAC_HI) ? FRAC_HI : sf_w);
        mqc_w = (mq_w < MINQ_LO) ? MINQ_LO : ((mq_w > ONE_32) ? ONE_32 : mq_w);
        prod  = r_md * r_fc;
        sd_sq = r_sd * r_sd;
    end

    always_ff @(posedge i_clk) begin
        r_fc      <= fc_w[QF-1:0];
        r_mqc     <= mqc_w[QF:0];
        r_sd      <= prod[15+QF:QF-GUARD_BITS];
        r_maxsq   <= r_md * r_md;
        r_md_zero <= (r_md == '0);
        r_start   <= sd_sq[2*SDW-1:2*GUARD_BITS];
        r_span    <= (r_maxsq > r_start) ? (r_maxsq - r_start) : '0;
        r_narrow  <= ((r_maxsq > r_start) ? (r_maxsq - r_start) : '0) <= SPAN_MIN;
    end

    // input stage: special cases and the dividend
    t_ctrl         n_in_ctrl, r_in_ctrl;
    logic [DW-1:0] r_in_rem;

    always_comb begin
        n_in_ctrl.valid   = start & ~busy;
        n_in_ctrl.last    = i_last;
        n_in_ctrl.byp     = 1'b1;
        n_in_ctrl.byp_one = 1'b1;
        if (r_md_zero) begin
            n_in_ctrl.byp_one = 1'b1;
        end else if (r_narrow || i_dist_sq <= r_start) begin
            n_in_ctrl.byp_one = (i_dist_sq <= r_start);
        end else if (i_dist_sq >= r_maxsq) begin
            n_in_ctrl.byp_one = 1'b0;
        end else begin
            n_in_ctrl.byp = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_ctrl <= '0;
        end else begin
            r_in_ctrl <= n_in_ctrl;
        end
        r_in_rem <= i_dist_sq - r_start;
    end

    // chain of division cells, one quotient bit each
    t_ctrl         c_ctrl [QF+1];
    logic [DW-1:0] c_rem  [QF+1];
    logic [QF-1:0] c_quot [QF+1];

    assign c_ctrl[0] = r_in_ctrl;
    assign c_rem[0]  = r_in_rem;
    assign c_quot[0] = '0;

    for (genvar g = 0; g < QF; g++) begin : g_div
        sdf_div_cell #(
            .DW (DW),
            .QW (QF)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (c_ctrl[g]),
            .i_rem   (c_rem[g]),
            .i_quot  (c_quot[g]),
            .i_span  (r_span),
            .o_ctrl  (c_ctrl[g+1]),
            .o_rem   (c_rem[g+1]),
            .o_quot  (c_quot[g+1])
        );
    end

    logic [QF:0] q_out;

    sdf_curve #(
        .QF (QF)
    ) u_curve (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (c_ctrl[QF]),
        .i_t     (c_quot[QF]),
        .i_mq    (r_mqc),
        .o_valid (o_valid),
        .o_last  (o_last_res),
        .o_q     (q_out)
    );

    assign o_quality = 17'(q_out);

endmodule

`default_nettype wire

// ===== tb/tb_smoothstep_distance_falloff_unit.sv =====
// ----------------------------------------------------------------------------
// tb_smoothstep_distance_falloff_unit
// Self-checking bench for the smoothstep distance falloff unit. Distance
// requests go in through start/busy, and the registers are set over the config
// channel while the pipe is empty. A local model predicts quality and the
// batch-end flag, and each result strobe is checked in order against it.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_smoothstep_distance_falloff_unit;
    import sdf_pkg::*;

    localparam int          PIPE_LAT   = Q_FRAC_BITS_DEF + 4;
    localparam int          WDOG_LIMIT = 5000;
    localparam logic [1:0]  CFG_IDX_SPARE = 2'd3;   // unmapped index, write is dropped
    localparam logic [63:0] ONE_Q    = 64'd1 << Q_FRAC_BITS_DEF;
    localparam logic [63:0] FRAC_MIN = (64'd15 << Q_FRAC_BITS_DEF) / 100;
    localparam logic [63:0] FRAC_MAX = (64'd95 << Q_FRAC_BITS_DEF) / 100;
    localparam logic [63:0] FLOOR_MIN = (64'd5 << Q_FRAC_BITS_DEF) / 100;
    localparam logic [63:0] NARROW_SPAN = (64'd1 << (2 * DIST_FRAC_BITS_DEF)) / 10000;

    typedef struct packed {
        logic [16:0] quality;
        logic        last;
    } t_falloff_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic        start;
    logic        busy;
    logic [31:0] i_dist_sq;
    logic        i_last;
    logic        o_valid;
    logic [16:0] o_quality;
    logic        o_last_res;

    smoothstep_distance_falloff_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .start       (start),
        .busy        (busy),
        .i_dist_sq   (i_dist_sq),
        .i_last      (i_last),
        .o_valid     (o_valid),
        .o_quality   (o_quality),
        .o_last_res  (o_last_res)
    );

    // register copies
    logic [15:0] max_dist_reg;
    logic [15:0] start_frac_reg;
    logic [16:0] min_q_reg;

    t_falloff_res quality_q[$];
    int idle_pct;
    int mismatches;
    int n_requests;
    int n_results;
    int n_writes;
    int wdog;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [63:0] clamp64(logic [63:0] v, logic [63:0] lo, logic [63:0] hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // start of the falloff as a squared distance
    function automatic logic [63:0] falloff_start_sq();
        logic [63:0] sd;
        sd = ({48'd0, max_dist_reg} * clamp64({48'd0, start_frac_reg}, FRAC_MIN, FRAC_MAX))
             >> (Q_FRAC_BITS_DEF - GUARD_BITS);
        return (sd * sd) >> (2 * GUARD_BITS);
    endfunction

    function automatic logic [16:0] predict_quality(logic [31:0] dsq);
        logic [63:0] d, md, fl, st, mx, span, t, t2, s, q;
        d  = {32'd0, dsq};
        md = {48'd0, max_dist_reg};
        if (md == 0) return ONE_Q[16:0];
        fl = clamp64({47'd0, min_q_reg}, FLOOR_MIN, ONE_Q);
        st = falloff_start_sq();
        mx = md * md;
        span = (mx > st) ? mx - st : 64'd0;
        if (span <= NARROW_SPAN) return (d <= st) ? ONE_Q[16:0] : fl[16:0];
        if (d <= st) return ONE_Q[16:0];
        if (d >= mx) return fl[16:0];
        t = ((d - st) << Q_FRAC_BITS_DEF) / span;
        if (t > ONE_Q) t = ONE_Q;
        t2 = (t * t) >> Q_FRAC_BITS_DEF;
        s = (t2 * (3 * ONE_Q - 2 * t)) >> Q_FRAC_BITS_DEF;
        if (s > ONE_Q) s = ONE_Q;
        q = ONE_Q - ((s * (ONE_Q - fl)) >> Q_FRAC_BITS_DEF);
        q = clamp64(q, fl, ONE_Q);
        return q[16:0];
    endfunction

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            n_results++;
            if (quality_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: quality=%0d last=%0b", o_quality, o_last_res);
            end else begin
                t_falloff_res e;
                e = quality_q.pop_front();
                if (e.quality !== o_quality || e.last !== o_last_res) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: quality exp %0d got %0d, last exp %0b got %0b",
                                 e.quality, o_quality, e.last, o_last_res);
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || o_valid || (start && !busy) || (i_cfg_valid && o_cfg_ready)) begin
            wdog <= 0;
        end else if (wdog >= WDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            wdog <= wdog + 1;
        end
    end

    task automatic send_req(logic [31:0] dsq, logic lst);
        t_falloff_res e;
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start = 1'b1;
        i_dist_sq = dsq;
        i_last = lst;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        e.quality = predict_quality(dsq);
        e.last = lst;
        quality_q.push_back(e);
        n_requests++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        start = 1'b0;
        while (quality_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [16:0] data);
        drain();
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_MAX_DIST:   max_dist_reg = data[15:0];
            CFG_START_FRAC: start_frac_reg = data[15:0];
            CFG_MIN_Q:      min_q_reg = data;
            default: ;
        endcase
        n_writes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_falloff(logic [16:0] md, logic [16:0] fr, logic [16:0] mq);
        write_reg(CFG_MAX_DIST, md);
        write_reg(CFG_START_FRAC, fr);
        write_reg(CFG_MIN_Q, mq);
    endtask

    // distance around the falloff band, sometimes anywhere
    function automatic logic [31:0] pick_dist();
        logic [63:0] st, mx, v;
        st = falloff_start_sq();
        mx = {48'd0, max_dist_reg} * {48'd0, max_dist_reg};
        case ($urandom_range(9))
            0: v = {$urandom, $urandom};
            1: v = st + $urandom_range(2) - 1;
            2: v = mx + $urandom_range(2) - 1;
            default: v = st + (({$urandom, $urandom}) % (mx - st + 3));
        endcase
        if (v[63:32] != 0) v = 64'hFFFF_FFFF;
        return v[31:0];
    endfunction

    task automatic test_reset_defaults();
        send_req(32'd0, 1'b0);
        send_req(32'hFFFF_FFFF, 1'b1);
        send_req(32'h0001_0000, 1'b0);
    endtask

    task automatic test_falloff_edges();
        logic [63:0] st, mx;
        set_falloff(17'hFFFF, 17'd0, 17'd0);            // fraction and floor clamp low
        st = falloff_start_sq();
        mx = 64'hFFFF * 64'hFFFF;
        send_req(32'd0, 1'b0);
        send_req(st[31:0], 1'b0);
        send_req(st[31:0] + 1, 1'b0);
        send_req(st[31:0] + (mx[31:0] - st[31:0]) / 2, 1'b1);
        send_req(mx[31:0] - 1, 1'b0);
        send_req(mx[31:0], 1'b0);
        send_req(32'hFFFF_FFFF, 1'b1);
        set_falloff(17'h1_2000, 17'hFFFF, 17'h1_FFFF);  // high bits dropped, clamp high
        send_req(32'h0FFF_FFFF, 1'b0);
        send_req(32'h2000_0000, 1'b1);
        write_reg(CFG_MIN_Q, 17'h1_0000);               // floor of exactly one
        send_req(32'h0100_0000, 1'b0);
        write_reg(CFG_IDX_SPARE, 17'h1_5555);
        send_req(32'h0040_0000, 1'b1);
    endtask

    task automatic test_narrow_span();
        // tiny outer distance leaves a span too small for the smooth part
        set_falloff(17'd1, 17'd32768, 17'd20000);
        send_req(32'd0, 1'b0);
        send_req(32'd1, 1'b0);
        send_req(32'd2, 1'b1);
        write_reg(CFG_MAX_DIST, 17'd3);
        send_req(32'd2, 1'b0);
        send_req(32'd8, 1'b0);
        send_req(32'd9, 1'b1);
        write_reg(CFG_MAX_DIST, 17'd0);
        send_req(32'hFFFF_FFFF, 1'b0);
    endtask

    task automatic test_random_phase(int pct, int n_cfg, int n_per);
        idle_pct = pct;
        for (int c = 0; c < n_cfg; c++) begin
            case ($urandom_range(5))
                0: set_falloff(17'hFFFF, 17'($urandom_range(17'h1_FFFF)),
                               17'($urandom_range(17'h1_FFFF)));
                1: set_falloff(17'($urandom_range(255)), 17'($urandom_range(65535)),
                               17'($urandom_range(65536)));
                default: set_falloff(17'($urandom_range(17'h1_FFFF)),
                                     17'($urandom_range(17'h1_FFFF)),
                                     17'($urandom_range(17'h1_FFFF)));
            endcase
            if ($urandom_range(9) == 0)
                write_reg(CFG_IDX_SPARE, 17'($urandom_range(17'h1_FFFF)));
            for (int k = 0; k < n_per; k++) send_req(pick_dist(), 1'($urandom_range(1)));
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_MAX_DIST;
        i_cfg_data = '0;
        start = 1'b0;
        i_dist_sq = '0;
        i_last = 1'b0;
        max_dist_reg = 16'd0;
        start_frac_reg = 16'd32768;
        min_q_reg = 17'd32768;
        idle_pct = 0;
        mismatches = 0;
        n_requests = 0;
        n_results = 0;
        n_writes = 0;
        wdog = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_falloff_edges();
        test_narrow_span();
        test_random_phase(0, 6, 32);
        test_random_phase(74, 6, 32);
        test_random_phase(6, 6, 32);
        test_random_phase(0, 6, 30);

        drain();
        $display("ran %0d requests, %0d results, %0d register writes", n_requests, n_results,
                 n_writes);
        $display("covered reset defaults, clamps, band edges, narrow span and random settings");
        if (mismatches == 0 && quality_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire
